[sv/assert_macros.svh]
// assertion macros used by the top-level rtl file
// no dependencies; define ASSERT_OFF to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[sv/mm4_pkg.sv]
// types and constants of the 4x4 fixed-point matrix multiplier
// no dependencies
package mm4_pkg;

   localparam int DIM       = 4;
   localparam int N_ELEM    = DIM * DIM;
   localparam int IDX_W     = $clog2(N_ELEM);
   localparam int LANE_W    = $clog2(DIM);
   localparam int ELEM_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int PAIR_W    = PROD_W + 1;
   localparam int SUM_W     = PROD_W + LANE_W;
   localparam int OP_W      = 2;

   localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

   localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   typedef struct packed {
      logic              write_a;
      logic              write_b;
      logic [IDX_W-1:0]  wr_index;
      logic              issue;
      logic [LANE_W-1:0] rd_row;
      logic [LANE_W-1:0] rd_col;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic pipe_active;
   } status_type;

endpackage

[sv/mm4_datapath.sv]
// datapath: banked element stores, four multiply lanes, adder tree, saturation
// depends on mm4_pkg
module mm4_datapath
   import mm4_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [ELEM_W-1:0] wr_value,
   output status_type        status,
   output logic              rsp_valid,
   output logic [IDX_W-1:0]  rsp_out_index,
   output logic [ELEM_W-1:0] rsp_out_value,
   output logic              rsp_saturated,
   output logic              rsp_last
);

   // a is banked by column, b by row, so each lane reads one entry per bank
   logic [ELEM_W-1:0] a_mem_ff [DIM][DIM];
   logic [ELEM_W-1:0] b_mem_ff [DIM][DIM];
   logic [N_ELEM-1:0] a_vld_ff;
   logic [N_ELEM-1:0] b_vld_ff;

   logic [LANE_W-1:0] a_bank, a_addr, b_bank, b_addr;

   logic [ELEM_W-1:0]        a_rd_ff [DIM];
   logic [ELEM_W-1:0]        b_rd_ff [DIM];
   logic signed [PROD_W-1:0] prod_ff [DIM];
   logic [PAIR_W-1:0]        pair_ff [2];
   logic [SUM_W-1:0]         sum_ff;

   logic [4:0]       vld_ff;
   logic [IDX_W-1:0] idx_ff  [4];
   logic [3:0]       last_ff;

   logic [ELEM_W-1:0] value_ff, value_in;
   logic              sat_ff, sat_in;
   logic [IDX_W-1:0]  out_idx_ff;
   logic              out_last_ff;

   logic [SUM_W-ELEM_W-FRAC_BITS:0] top_bits;

   assign a_bank = cmd.wr_index[LANE_W-1:0];
   assign a_addr = cmd.wr_index[IDX_W-1:LANE_W];
   assign b_bank = cmd.wr_index[IDX_W-1:LANE_W];
   assign b_addr = cmd.wr_index[LANE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.write_a) begin
         a_mem_ff[a_bank][a_addr] <= wr_value;
      end
      if (cmd.write_b) begin
         b_mem_ff[b_bank][b_addr] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
         b_vld_ff <= '0;
      end else begin
         if (cmd.write_a) begin
            a_vld_ff[cmd.wr_index] <= 1'b1;
         end
         if (cmd.write_b) begin
            b_vld_ff[cmd.wr_index] <= 1'b1;
         end
      end
   end

   // read stage; entries never written read as zero
   always_ff @(posedge clock) begin
      for (int j = 0; j < DIM; j++) begin
         a_rd_ff[j] <= a_vld_ff[{cmd.rd_row, LANE_W'(j)}] ? a_mem_ff[j][cmd.rd_row] : '0;
         b_rd_ff[j] <= b_vld_ff[{LANE_W'(j), cmd.rd_col}] ? b_mem_ff[j][cmd.rd_col] : '0;
      end
   end

   // multiply, pair add, final add
   always_ff @(posedge clock) begin
      for (int j = 0; j < DIM; j++) begin
         prod_ff[j] <= $signed(a_rd_ff[j]) * $signed(b_rd_ff[j]);
      end
      pair_ff[0] <= {prod_ff[0][PROD_W-1], prod_ff[0]} + {prod_ff[1][PROD_W-1], prod_ff[1]};
      pair_ff[1] <= {prod_ff[2][PROD_W-1], prod_ff[2]} + {prod_ff[3][PROD_W-1], prod_ff[3]};
      sum_ff     <= {pair_ff[0][PAIR_W-1], pair_ff[0]} + {pair_ff[1][PAIR_W-1], pair_ff[1]};
   end

   // shift back by the fraction and clip when the upper bits are not all sign
   assign top_bits = sum_ff[SUM_W-1:ELEM_W+FRAC_BITS-1];

   always_comb begin
      sat_in   = !((&top_bits) || !(|top_bits));
      value_in = sum_ff[ELEM_W+FRAC_BITS-1:FRAC_BITS];
      if (sat_in) begin
         value_in = sum_ff[SUM_W-1] ? SAT_MIN : SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff[0]   <= {cmd.rd_row, cmd.rd_col};
      last_ff[0]  <= cmd.last;
      for (int s = 1; s < 4; s++) begin
         idx_ff[s]  <= idx_ff[s-1];
         last_ff[s] <= last_ff[s-1];
      end
      value_ff    <= value_in;
      sat_ff      <= sat_in;
      out_idx_ff  <= idx_ff[3];
      out_last_ff <= last_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], cmd.issue};
      end
   end

   assign status.pipe_active = |vld_ff;

   assign rsp_valid     = vld_ff[4];
   assign rsp_out_index = out_idx_ff;
   assign rsp_out_value = value_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_last      = out_last_ff;

endmodule

[sv/mm4_ctrl.sv]
// controller: accepts items, sequences the sixteen element reads of a product
// depends on mm4_pkg
module mm4_ctrl
   import mm4_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [OP_W-1:0]  req_opcode,
   input  logic [IDX_W-1:0] req_elem_index,
   input  status_type       status,
   output logic             busy,
   output cmd_type          cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept && req_opcode == OP_COMPUTE) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(N_ELEM - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_active) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign cmd.write_a  = accept && req_opcode == OP_LOAD_A;
   assign cmd.write_b  = accept && req_opcode == OP_LOAD_B;
   assign cmd.wr_index = req_elem_index;
   assign cmd.issue    = (state_ff == ST_RUN);
   assign cmd.rd_row   = cnt_ff[IDX_W-1:LANE_W];
   assign cmd.rd_col   = cnt_ff[LANE_W-1:0];
   assign cmd.last     = (cnt_ff == IDX_W'(N_ELEM - 1));

endmodule

[sv/matrix_multiply_4x4_top.sv]
// top level of the 4x4 signed Q16.16 matrix multiplier
// depends on mm4_pkg, mm4_ctrl, mm4_datapath and assert_macros.svh
`include "assert_macros.svh"

// A load item (opcode 0 for A, 1 for B) writes one element and busy stays low,
// so loads can be issued every cycle while no compute item is running. A compute
// item holds busy while the sixteen elements of A x B are read one per cycle from
// the banked stores (one row of A and one column of B per cycle) and run through
// a five-stage multiply, add-tree and saturate pipeline. Results appear one per
// cycle in index order, each for exactly one cycle with rsp_valid high; the
// receiver cannot stall them. Opcode 3 is accepted and ignored. Both stores read
// as zero after reset.
module matrix_multiply_4x4_top
   import mm4_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [IDX_W-1:0]  req_elem_index,
   input  logic [ELEM_W-1:0] req_elem_value,
   output logic              rsp_valid,
   output logic [IDX_W-1:0]  rsp_out_index,
   output logic [ELEM_W-1:0] rsp_out_value,
   output logic              rsp_saturated,
   output logic              rsp_last
);

   cmd_type    cmd;
   status_type status;

   mm4_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_opcode     (req_opcode),
      .req_elem_index (req_elem_index),
      .status         (status),
      .busy           (busy),
      .cmd            (cmd)
   );

   mm4_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .wr_value      (req_elem_value),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_out_index (rsp_out_index),
      .rsp_out_value (rsp_out_value),
      .rsp_saturated (rsp_saturated),
      .rsp_last      (rsp_last)
   );

   `ASSERT_NEXT(a_compute_busy, clock, reset, start && !busy && req_opcode == OP_COMPUTE, busy)
   `ASSERT_IMPL(a_rsp_in_busy, clock, reset, rsp_valid, busy)
   `ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_last, !rsp_valid)
   `ASSERT_IMPL(a_last_index, clock, reset, rsp_valid && rsp_last, rsp_out_index == IDX_W'(N_ELEM - 1))

endmodule

[tb/mm4_checker.sv]
`timescale 1ns / 1ps
// product checker for the 4x4 fixed-point matrix multiplier: mirrors both stores,
// predicts the elements of every product pass and compares them as they leave
// depends on mm4_pkg
module mm4_checker
   import mm4_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [IDX_W-1:0]  req_elem_index,
   input  logic [ELEM_W-1:0] req_elem_value,
   input  logic              rsp_valid,
   input  logic [IDX_W-1:0]  rsp_out_index,
   input  logic [ELEM_W-1:0] rsp_out_value,
   input  logic              rsp_saturated,
   input  logic              rsp_last,
   output int                errors,
   output int                pending,
   output int                checked,
   output int                clipped
);

   typedef struct {
      logic [IDX_W-1:0]  index;
      logic [ELEM_W-1:0] value;
      logic              sat;
      logic              last;
   } product_elem_type;

   product_elem_type  product_q[$];
   logic [ELEM_W-1:0] store_a [N_ELEM];
   logic [ELEM_W-1:0] store_b [N_ELEM];

   function automatic void queue_product();
      int r;
      int c;
      int j;
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] scaled;
      logic signed [SUM_W-1:0] lim_hi;
      logic signed [SUM_W-1:0] lim_lo;
      product_elem_type e;
      lim_hi = $signed(SAT_MAX);
      lim_lo = $signed(SAT_MIN);
      for (r = 0; r < DIM; r++) begin
         for (c = 0; c < DIM; c++) begin
            acc = '0;
            for (j = 0; j < DIM; j++) begin
               acc = acc + $signed(store_a[r*DIM+j]) * $signed(store_b[j*DIM+c]);
            end
            scaled  = acc >>> FRAC_BITS;
            e.index = IDX_W'(r*DIM + c);
            e.last  = (r*DIM + c == N_ELEM - 1);
            if (scaled > lim_hi) begin
               e.value = SAT_MAX;
               e.sat   = 1'b1;
            end else if (scaled < lim_lo) begin
               e.value = SAT_MIN;
               e.sat   = 1'b1;
            end else begin
               e.value = scaled[ELEM_W-1:0];
               e.sat   = 1'b0;
            end
            product_q.push_back(e);
         end
      end
   endfunction

   always @(posedge clock) begin
      product_elem_type want;
      if (reset) begin
         product_q.delete();
         foreach (store_a[i]) begin
            store_a[i] = '0;
            store_b[i] = '0;
         end
      end else begin
         if (rsp_valid) begin
            if (product_q.size() == 0) begin
               $display("%0t: unexpected result: index %0d value %h sat %b last %b",
                        $time, rsp_out_index, rsp_out_value, rsp_saturated, rsp_last);
               errors++;
            end else begin
               want = product_q.pop_front();
               checked++;
               if (want.sat) clipped++;
               if (rsp_out_index !== want.index || rsp_out_value !== want.value ||
                   rsp_saturated !== want.sat || rsp_last !== want.last) begin
                  $display("%0t: expected index %0d value %h sat %b last %b",
                           $time, want.index, want.value, want.sat, want.last);
                  $display("%0t:   actual index %0d value %h sat %b last %b",
                           $time, rsp_out_index, rsp_out_value, rsp_saturated, rsp_last);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            case (req_opcode)
               OP_LOAD_A: begin
                  store_a[req_elem_index] = req_elem_value;
               end
               OP_LOAD_B: begin
                  store_b[req_elem_index] = req_elem_value;
               end
               OP_COMPUTE: begin
                  queue_product();
               end
               default: begin
               end
            endcase
         end
      end
      pending = product_q.size();
   end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// top of the 4x4 fixed-point matrix multiplier testbench: clock, reset, item stimulus
// and verdict; depends on mm4_pkg, matrix_multiply_4x4_top and mm4_checker
module testbench;
   import mm4_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
   localparam int              N_RANDOM    = 400;
   localparam int              CYCLE_LIMIT = 200000;
   localparam int              DRAIN       = 40;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [OP_W-1:0]   req_opcode;
   logic [IDX_W-1:0]  req_elem_index;
   logic [ELEM_W-1:0] req_elem_value;
   logic              rsp_valid;
   logic [IDX_W-1:0]  rsp_out_index;
   logic [ELEM_W-1:0] rsp_out_value;
   logic              rsp_saturated;
   logic              rsp_last;

   int errors;
   int pending;
   int checked;
   int clipped;
   int cycles;
   int n_loads;
   int n_passes;
   int n_ignored;

   matrix_multiply_4x4_top dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_elem_index (req_elem_index),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_out_index  (rsp_out_index),
      .rsp_out_value  (rsp_out_value),
      .rsp_saturated  (rsp_saturated),
      .rsp_last       (rsp_last)
   );

   mm4_checker product_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_elem_index (req_elem_index),
      .req_elem_value (req_elem_value),
      .rsp_valid      (rsp_valid),
      .rsp_out_index  (rsp_out_index),
      .rsp_out_value  (rsp_out_value),
      .rsp_saturated  (rsp_saturated),
      .rsp_last       (rsp_last),
      .errors         (errors),
      .pending        (pending),
      .checked        (checked),
      .clipped        (clipped)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("matrix_multiply_4x4_top: mismatch");
         $finish;
      end
   end

   // small Q16.16 values keep sums in range, larger ones push toward clipping, the last class gives corner values
   function automatic logic [ELEM_W-1:0] pick_value(input int cls);
      logic [31:0] r;
      r = $urandom;
      case (cls)
         0: pick_value = {{14{r[17]}}, r[17:0]};
         1: pick_value = {{8{r[23]}}, r[23:0]};
         2: pick_value = r;
         default: begin
            case ($urandom_range(0, 5))
               0: pick_value = SAT_MAX;
               1: pick_value = SAT_MIN;
               2: pick_value = '0;
               3: pick_value = '1;
               4: pick_value = 32'h0001_0000;
               default: pick_value = 32'hFFFF_0000;
            endcase
         end
      endcase
   endfunction

   function automatic int pick_class();
      int w;
      w = $urandom_range(0, 9);
      if (w < 5) pick_class = 0;
      else if (w < 7) pick_class = 1;
      else if (w < 9) pick_class = 2;
      else pick_class = 3;
   endfunction

   // holds start until the item is taken
   task automatic send(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                       input logic [ELEM_W-1:0] val);
      @(negedge clock);
      start          = 1'b1;
      req_opcode     = op;
      req_elem_index = idx;
      req_elem_value = val;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      case (op)
         OP_LOAD_A, OP_LOAD_B: n_loads++;
         OP_COMPUTE: n_passes++;
         default: n_ignored++;
      endcase
   endtask

   task automatic pause(input int n);
      repeat (n) begin
         @(negedge clock);
         start          = 1'b0;
         req_opcode     = OP_W'($urandom);
         req_elem_index = IDX_W'($urandom);
         req_elem_value = $urandom;
      end
   endtask

   task automatic send_random(output int counted);
      int w;
      logic [OP_W-1:0] op;
      w = $urandom_range(0, 99);
      if (w < 44) op = OP_LOAD_A;
      else if (w < 88) op = OP_LOAD_B;
      else if (w < 97) op = OP_COMPUTE;
      else op = OP_UNUSED;
      send(op, IDX_W'($urandom_range(0, N_ELEM - 1)), pick_value(pick_class()));
      counted = (op != OP_UNUSED);
   endtask

   // fills both matrices from one value class, then runs a product pass
   task automatic reload_and_compute(output int counted);
      int cls;
      int i;
      cls = pick_class();
      for (i = 0; i < N_ELEM; i++) begin
         send(OP_LOAD_A, IDX_W'(i), pick_value(cls));
         send(OP_LOAD_B, IDX_W'(i), pick_value(cls));
         if ($urandom_range(0, 7) == 0) pause($urandom_range(1, 4));
      end
      send(OP_COMPUTE, IDX_W'($urandom), $urandom);
      counted = 2 * N_ELEM + 1;
   endtask

   initial begin
      int items;
      int burst;
      int got;
      int i;
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_LOAD_A;
      req_elem_index = '0;
      req_elem_value = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero stores, clipping both ways, unused opcode, corner elements
      send(OP_COMPUTE, '1, '1);
      for (i = 0; i < DIM; i++) send(OP_LOAD_A, IDX_W'(i), SAT_MAX);
      for (i = 0; i < DIM; i++) send(OP_LOAD_B, IDX_W'(i*DIM), SAT_MAX);
      for (i = 0; i < DIM; i++) send(OP_LOAD_B, IDX_W'(i*DIM + 1), SAT_MIN);
      send(OP_UNUSED, '0, '0);
      send(OP_COMPUTE, '0, '0);
      send(OP_LOAD_A, 4'd15, SAT_MIN);
      send(OP_LOAD_B, 4'd15, SAT_MIN);
      send(OP_LOAD_A, 4'd5, 32'h0001_0000);
      send(OP_LOAD_B, 4'd6, 32'hFFFF_8000);
      send(OP_COMPUTE, '0, '1);
      pause(3);

      items = 0;
      while (items < N_RANDOM) begin
         if ($urandom_range(0, 5) == 0) begin
            reload_and_compute(got);
            items += got;
         end else begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
               send_random(got);
               items += got;
            end
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
      end
      pause(1);

      while (pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);

      $display("covered %0d loads, %0d product passes and %0d ignored items",
               n_loads, n_passes, n_ignored);
      $display("checked %0d result elements, %0d of them clipped", checked, clipped);
      if (errors == 0 && pending == 0) begin
         $display("matrix_multiply_4x4_top: match");
      end else begin
         $display("matrix_multiply_4x4_top: mismatch");
      end
      $finish;
   end

endmodule
